// ===== rtl/core/sm3_pkg.sv =====
// Shared types and constants for the SM3 hash engine.
package sm3_pkg;

   localparam int WordWidth  = 32;
   localparam int BlockWords = 16;
   localparam int DigestWords = 8;
   localparam int Rounds     = 64;
   localparam int QueueDepthDefault = 4;

   localparam logic [31:0] TjLow  = 32'h79CC4519;
   localparam logic [31:0] TjHigh = 32'h7A879D8A;
   localparam logic [31:0] PadWord = 32'h8000_0000;
   localparam logic [7:0]  PadByte = 8'h80;

   typedef logic [31:0] word_type;

   // Word handed from the front end to the compression back end.
   typedef struct packed {
      word_type data;
      logic     final_word;   // second length word: emit digest after block
   } fwd_type;

   localparam word_type Iv [DigestWords] = '{
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

// ===== rtl/core/sm3_if.sv =====
// Valid/ready channel interfaces for requests and digest words.
interface sm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic [2:0]  valid_bytes;
   logic        last_word;
   modport source (output valid, message_word, valid_bytes, last_word, input ready);
   modport sink   (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  digest_index;
   logic        digest_done;
   modport source (output valid, digest_word, digest_index, digest_done, input ready);
   modport sink   (input valid, digest_word, digest_index, digest_done, output ready);
endinterface

// ===== rtl/core/sm3_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module sm3_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/core/sm3_front.sv =====
// Front end: takes requests, pads the last one, emits a word stream.
module sm3_front
   import sm3_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   sm3_req_if.sink req,
   output logic    fwd_valid,
   output fwd_type fwd_data,
   input  logic    fwd_ready
);
   typedef enum logic [1:0] {S_IDLE, S_PAD, S_LEN_HI, S_LEN_LO} state_type;

   state_type   state_ff;
   logic [3:0]  count_ff;
   logic [63:0] len_ff;
   logic        pad80_ff;   // 0x80 word still owed (last word was full)

   logic [2:0]  vb;
   logic [63:0] len_last;
   word_type    keep_mask;
   word_type    pad_word;

   always_comb begin
      vb = (req.valid_bytes > 3'd4) ? 3'd4 : req.valid_bytes;
      len_last = len_ff + {58'd0, vb, 3'd0};
      keep_mask = (vb == 3'd0) ? '0 : ~(32'hFFFF_FFFF >> {vb[1:0], 3'd0});
      pad_word = (req.message_word & keep_mask) |
                 (word_type'(PadByte) << (5'd24 - {vb[1:0], 3'd0}));
   end

   assign req.ready = (state_ff == S_IDLE) && fwd_ready;

   always_comb begin
      fwd_valid = 1'b0;
      fwd_data  = '{data: '0, final_word: 1'b0};
      case (state_ff)
         S_IDLE: begin
            fwd_valid = req.valid;
            if (req.last_word && vb != 3'd4) begin
               fwd_data.data = pad_word;
            end else begin
               fwd_data.data = req.message_word;
            end
         end
         S_PAD: begin
            fwd_valid = 1'b1;
            fwd_data.data = pad80_ff ? PadWord : '0;
         end
         S_LEN_HI: begin
            fwd_valid = 1'b1;
            fwd_data.data = len_ff[63:32];
         end
         S_LEN_LO: begin
            fwd_valid = 1'b1;
            fwd_data.data = len_ff[31:0];
            fwd_data.final_word = 1'b1;
         end
         default: ;
      endcase
   end

   // count_ff wraps to zero on its own after the second length word (slot 15)
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         len_ff   <= '0;
         pad80_ff <= 1'b0;
      end else if (fwd_valid && fwd_ready) begin
         count_ff <= count_ff + 4'd1;
         case (state_ff)
            S_IDLE: begin
               if (!req.last_word) begin
                  len_ff <= len_ff + 64'd32;
               end else begin
                  len_ff   <= len_last;
                  pad80_ff <= (vb == 3'd4);
                  state_ff <= (vb != 3'd4 && count_ff == 4'd13) ? S_LEN_HI : S_PAD;
               end
            end
            S_PAD: begin
               pad80_ff <= 1'b0;
               if (count_ff == 4'd13) state_ff <= S_LEN_HI;
            end
            S_LEN_HI: state_ff <= S_LEN_LO;
            S_LEN_LO: begin
               state_ff <= S_IDLE;
               len_ff   <= '0;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/core/sm3_queue.sv =====
// Small FIFO between front end and back end.
module sm3_queue
   import sm3_pkg::*;
#(
   parameter int Depth = QueueDepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  fwd_type in_data,
   output logic    in_ready,
   output logic    out_valid,
   output fwd_type out_data,
   input  logic    out_ready
);
   localparam int AW = $clog2(Depth);

   fwd_type       slot_ff [Depth];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;
   logic          push, pop;

   assign in_ready  = (cnt_ff != (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = slot_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_data;
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule

// ===== rtl/core/sm3_back.sv =====
// Back end: block buffer, message schedule, 64 rounds, digest output.
module sm3_back
   import sm3_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  fwd_type  in_data,
   output logic     in_ready,
   sm3_rsp_if.source rsp
);
   typedef enum logic [2:0] {S_FILL, S_LOAD, S_ROUND, S_FOLD, S_OUT} state_type;

   state_type  state_ff;
   logic [3:0] wcnt_ff;
   logic [4:0] ld_ff;          // buffer read counter during load (0..16)
   logic [5:0] rnd_ff;
   logic [2:0] oidx_ff;
   logic       final_ff;
   word_type   cv_ff [DigestWords];
   word_type   v_ff  [DigestWords];
   word_type   w_ff  [BlockWords];   // sliding window of W[j..j+15]
   logic       rsp_valid_ff;
   word_type   rsp_word_ff;
   logic [2:0] rsp_idx_ff;

   logic     ram_we;
   word_type ram_q;
   logic [3:0] ram_ra;
   logic     out_load;

   assign in_ready = (state_ff == S_FILL);
   assign ram_we   = in_valid && in_ready;
   assign ram_ra   = ld_ff[3:0];
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);

   sm3_ram #(.Width(WordWidth), .Depth(BlockWords)) u_buf (
      .clock, .wr_en(ram_we), .wr_addr(wcnt_ff), .wr_data(in_data.data),
      .rd_addr(ram_ra), .rd_data(ram_q)
   );

   // round datapath
   word_type tj, a12, ss1, ss2, ff, gg, tt1, tt2, wnew;
   always_comb begin
      tj  = rotl((rnd_ff < 6'd16) ? TjLow : TjHigh, rnd_ff[4:0]);
      a12 = rotl(v_ff[0], 5'd12);
      ss1 = rotl(a12 + v_ff[4] + tj, 5'd7);
      ss2 = ss1 ^ a12;
      if (rnd_ff < 6'd16) begin
         ff = v_ff[0] ^ v_ff[1] ^ v_ff[2];
         gg = v_ff[4] ^ v_ff[5] ^ v_ff[6];
      end else begin
         ff = (v_ff[0] & v_ff[1]) | (v_ff[0] & v_ff[2]) | (v_ff[1] & v_ff[2]);
         gg = (v_ff[4] & v_ff[5]) | (~v_ff[4] & v_ff[6]);
      end
      tt1 = ff + v_ff[3] + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2 = gg + v_ff[7] + ss1 + w_ff[0];
      wnew = perm1(w_ff[0] ^ w_ff[7] ^ rotl(w_ff[13], 5'd15))
             ^ rotl(w_ff[3], 5'd7) ^ w_ff[10];
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.digest_word  = rsp_word_ff;
   assign rsp.digest_index = rsp_idx_ff;
   assign rsp.digest_done  = (rsp_idx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FILL;
         wcnt_ff  <= '0;
         ld_ff    <= '0;
         rnd_ff   <= '0;
         oidx_ff  <= '0;
         final_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DigestWords; i++) cv_ff[i] <= Iv[i];
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.valid && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_FILL: begin
               if (ram_we) begin
                  wcnt_ff <= wcnt_ff + 4'd1;
                  if (wcnt_ff == 4'd15) begin
                     final_ff <= in_data.final_word;
                     ld_ff    <= '0;
                     state_ff <= S_LOAD;
                  end
               end
            end
            S_LOAD: begin
               // RAM data appears in the cycle after its address
               ld_ff <= ld_ff + 5'd1;
               if (ld_ff != 5'd0) begin
                  for (int i = 0; i < BlockWords-1; i++) w_ff[i] <= w_ff[i+1];
                  w_ff[BlockWords-1] <= ram_q;
               end
               if (ld_ff == 5'd16) begin
                  for (int i = 0; i < DigestWords; i++) v_ff[i] <= cv_ff[i];
                  rnd_ff   <= '0;
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               v_ff[3] <= v_ff[2];
               v_ff[2] <= rotl(v_ff[1], 5'd9);
               v_ff[1] <= v_ff[0];
               v_ff[0] <= tt1;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= rotl(v_ff[5], 5'd19);
               v_ff[5] <= v_ff[4];
               v_ff[4] <= perm0(tt2);
               for (int i = 0; i < BlockWords-1; i++) w_ff[i] <= w_ff[i+1];
               w_ff[BlockWords-1] <= wnew;
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'(Rounds-1)) state_ff <= S_FOLD;
            end
            S_FOLD: begin
               for (int i = 0; i < DigestWords; i++) cv_ff[i] <= cv_ff[i] ^ v_ff[i];
               oidx_ff  <= '0;
               state_ff <= final_ff ? S_OUT : S_FILL;
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_word_ff  <= cv_ff[oidx_ff];
                  rsp_idx_ff   <= oidx_ff;
                  oidx_ff      <= oidx_ff + 3'd1;
                  if (oidx_ff == 3'd7) begin
                     for (int i = 0; i < DigestWords; i++) cv_ff[i] <= Iv[i];
                     state_ff <= S_FILL;
                  end
               end
            end
            default: state_ff <= S_FILL;
         endcase
      end
   end
endmodule

// ===== rtl/core/sm3_hash_engine.sv =====
// Top level of the SM3 hash engine: front end, word queue, compression back end.
//
// SM3 (GB/T 32905) hash engine. Requests carry one big-endian 32-bit message
// word, a count of valid leading bytes and a last flag; a request without the
// last flag always counts four bytes. The front end accepts one request per
// cycle while the word queue has room and, on the last request, generates the
// 0x80 pad, zero fill and 64-bit bit length itself (up to 18 extra words, one
// per cycle while the queue has room, during which no request is taken). The back
// end collects 16 words in a block RAM, then loads the schedule window, runs the
// 64 rounds (one round per cycle, the single round unit sets the rate) and folds
// into the chaining value; it takes no words of the next block until the fold
// is done and any digest is out. After the final block the eight digest
// words leave on the response channel, index 0 first, digest_done on index 7,
// and the engine re-arms with the initial value for the next message.
module sm3_hash_engine
   import sm3_pkg::*;
#(
   parameter int QueueDepth = QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   sm3_req_if.sink    req,
   sm3_rsp_if.source  rsp
);
   logic    f_valid, f_ready, b_valid, b_ready;
   fwd_type f_data, b_data;

   sm3_front u_front (
      .clock, .reset, .req,
      .fwd_valid(f_valid), .fwd_data(f_data), .fwd_ready(f_ready)
   );

   sm3_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_data(f_data), .in_ready(f_ready),
      .out_valid(b_valid), .out_data(b_data), .out_ready(b_ready)
   );

   sm3_back u_back (
      .clock, .reset,
      .in_valid(b_valid), .in_data(b_data), .in_ready(b_ready), .rsp
   );
endmodule

// ===== rtl/core/sm3_checker.sv =====
// Port-level assertions for the SM3 hash engine, bound to the top level.
module sm3_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_digest_index,
   input logic        rsp_digest_done
);
   a_done_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digest_done == (rsp_digest_index == 3'd7)))
      else $error("digest_done mismatch");

   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_digest_done) ##1 rsp_valid
      |-> rsp_digest_index == $past(rsp_digest_index) + 3'd1)
      else $error("digest index skipped");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_digest_word))
      else $error("stalled response changed");
endmodule

bind sm3_hash_engine sm3_checker u_checker (
   .clock, .reset,
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_digest_word(rsp.digest_word), .rsp_digest_index(rsp.digest_index),
   .rsp_digest_done(rsp.digest_done)
);
